>>> hw/rtl/ctre_pkg.sv
// ctre_pkg: shared widths, configuration codes and prototype coefficients
// for the crossover target response evaluator. No dependencies.
package ctre_pkg;

    localparam int FREQ_BITS_DEF = 20;
    localparam int OUT_FRAC_DEF  = 16;

    localparam int ORDER_W   = 3;
    localparam int KIND_W    = 3;
    localparam int CORNER_W  = 20;
    localparam int GAIN_W    = 20;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 20;
    localparam int OUT_W     = 24;

    localparam int RQ_W  = 31;
    localparam int CO_W  = 27;
    localparam int AM_W  = 26;
    localparam int NUM_W = 23;
    localparam int QB    = 33;
    localparam int NPOW  = 5;

    localparam int OUT_POS_MAX = 8388607;
    localparam int OUT_NEG_MAG = 8388608;

    localparam logic [NUM_W-1:0] Q22_ONE = 23'd4194304;
    localparam logic [RQ_W-1:0]  Q30_ONE = 31'd1073741824;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORDER   = 3'd0,
        CFG_KIND    = 3'd1,
        CFG_LOWPASS = 3'd2,
        CFG_CORNER  = 3'd3,
        CFG_GAIN    = 3'd4
    } t_cfg_idx;

    localparam logic [KIND_W-1:0] KIND_BESSEL = 3'd0;
    localparam logic [KIND_W-1:0] KIND_BUTTER = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CHEBY  = 3'd2;

    localparam logic [CO_W-1:0] C_ONE    = 27'd16777216;
    localparam logic [CO_W-1:0] C_TWO    = 27'd33554432;
    localparam logic [CO_W-1:0] C_FOUR   = 27'd67108864;
    localparam logic [CO_W-1:0] C_SQRT3  = 27'd29058991;
    localparam logic [CO_W-1:0] C_SQRT2  = 27'd23726566;
    localparam logic [CO_W-1:0] C_BES4_1 = 27'd53703868;
    localparam logic [CO_W-1:0] C_BES4_2 = 27'd73685533;
    localparam logic [CO_W-1:0] C_BES4_3 = 27'd52412023;
    localparam logic [CO_W-1:0] C_BUT4_1 = 27'd43838865;
    localparam logic [CO_W-1:0] C_BUT4_2 = 27'd57277415;
    localparam logic [CO_W-1:0] C_LR4_1  = 27'd47453133;

    typedef logic [NPOW-1:0][RQ_W-1:0] t_rp;

    // coefficient idx of the order n prototype, Q24
    function automatic logic [CO_W-1:0] coef(input logic [2:0] n, input logic [2:0] kind,
                                              input logic [2:0] idx);
        logic [CO_W-1:0] c;
        c = '0;
        if (idx == 3'd0 || idx == n) begin
            c = C_ONE;
        end else if (idx < n) begin
            unique case (n)
                3'd2: begin
                    if (kind == KIND_BESSEL) c = C_SQRT3;
                    else if (kind == KIND_BUTTER) c = C_SQRT2;
                    else if (kind == KIND_CHEBY) c = C_ONE;
                    else c = C_TWO;
                end
                3'd3: c = C_TWO;
                3'd4: begin
                    if (kind == KIND_BESSEL) begin
                        c = (idx == 3'd1) ? C_BES4_1 : (idx == 3'd2) ? C_BES4_2 : C_BES4_3;
                    end else if (kind == KIND_BUTTER) begin
                        c = (idx == 3'd2) ? C_BUT4_2 : C_BUT4_1;
                    end else begin
                        c = (idx == 3'd2) ? C_FOUR : C_LR4_1;
                    end
                end
                default: c = '0;
            endcase
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/crossover_target_response_eval_core.sv
// crossover_target_response_eval_core: top level of the crossover target response
// evaluator. Depends on ctre_pkg, ctre_div_cell and ctre_pow_cell.
//
// Usage: each frequency transfer on the input channel yields one complex response
// gain / P(jw) on the output channel, in order. Configuration writes (order, kind,
// low-pass select, corner, gain) go over the cfg channel, which is always ready;
// the user must make them while no item is in flight; the block does not enforce it.
// Throughput: one item per cycle while the skid register is empty. The pipeline is
// made of the input stage, the chain of divider cells for the frequency ratio (31
// cells, one quotient bit per cell), the three power cells, six arithmetic stages,
// the chains for the two output parts (33 cells each) and the output register.
// Reset clears the pipeline valid bits and the output and skid valid flags, and
// loads the default configuration.
// When the receiver stalls, the pipeline keeps moving until one more result
// lands in a skid register; o_in_ready then drops until the skid drains.
module crossover_target_response_eval_core #(
    parameter int FREQ_BITS     = ctre_pkg::FREQ_BITS_DEF,
    parameter int OUT_FRAC_BITS = ctre_pkg::OUT_FRAC_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [FREQ_BITS-1:0]          i_frequency,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [ctre_pkg::OUT_W-1:0] o_response_real,
    output logic signed [ctre_pkg::OUT_W-1:0] o_response_imag,
    output logic                          o_saturated,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ctre_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ctre_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import ctre_pkg::*;

    localparam int UP    = (OUT_FRAC_BITS >= 16) ? OUT_FRAC_BITS - 16 : 0;
    localparam int DN    = (OUT_FRAC_BITS < 16) ? 16 - OUT_FRAC_BITS : 0;
    localparam int HW    = (FREQ_BITS > CORNER_W) ? FREQ_BITS : CORNER_W;
    localparam int NW    = HW + RQ_W;
    localparam int PR_W  = CO_W + RQ_W;
    localparam int AC_W  = PR_W + 3;
    localparam int SQ_W  = 2 * AM_W;
    localparam int DEN_W = SQ_W + 1 + DN;
    localparam int GS_W  = GAIN_W + UP;
    localparam int NA_W  = NUM_W + AM_W;
    localparam int LO_W  = 25;
    localparam int P_W   = GS_W + NA_W;
    localparam int DV_W  = (P_W > DEN_W + QB) ? P_W : DEN_W + QB;
    localparam int NSTG  = 1 + RQ_W + 3 + 6 + QB;

    // configuration registers
    logic [ORDER_W-1:0]  r_order;
    logic [KIND_W-1:0]   r_kind;
    logic                r_lowpass;
    logic [CORNER_W-1:0] r_corner;
    logic [GAIN_W-1:0]   r_gain;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order   <= 3'd2;
            r_kind    <= KIND_BUTTER;
            r_lowpass <= 1'b1;
            r_corner  <= 20'd16000;
            r_gain    <= 20'd65536;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ORDER:   r_order   <= i_cfg_data[ORDER_W-1:0];
                CFG_KIND:    r_kind    <= i_cfg_data[KIND_W-1:0];
                CFG_LOWPASS: r_lowpass <= i_cfg_data[0];
                CFG_CORNER:  r_corner  <= i_cfg_data[CORNER_W-1:0];
                CFG_GAIN:    r_gain    <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic            r_skid_v;
    logic            r_out_v;
    logic [NSTG-1:0] r_vld;
    logic            w_en;
    logic            w_in_fire;
    logic            w_out_free;
    logic            w_last_v;

    assign w_en       = !r_skid_v;
    assign o_in_ready = w_en;
    assign w_in_fire  = i_in_valid & w_en;
    assign w_out_free = !r_out_v || i_out_ready;
    assign w_last_v   = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], w_in_fire};
        end
    end

    // input stage: order the frequency and the corner
    logic [CORNER_W-1:0] w_fc;
    logic [HW-1:0]       w_f;
    logic [HW-1:0]       w_fcx;
    logic                w_lt;
    logic                w_gt;
    logic [HW-1:0]       r_s0_lo;
    logic [HW-1:0]       r_s0_hi;
    logic                r_s0_scaled;
    logic [NW-1:0]       w_n;

    always_comb begin
        w_fc  = (r_corner == '0) ? CORNER_W'(1) : r_corner;
        w_f   = HW'(i_frequency);
        w_fcx = HW'(w_fc);
        w_lt  = w_f < w_fcx;
        w_gt  = w_f > w_fcx;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_lo     <= w_lt ? w_f : w_fcx;
            r_s0_hi     <= w_lt ? w_fcx : w_f;
            r_s0_scaled <= r_lowpass ? w_gt : w_lt;
        end
    end

    assign w_n = (NW'(r_s0_lo) << (RQ_W - 1)) + NW'(r_s0_hi >> 1);

    // ratio divider chain
    logic [HW-1:0]   w_rrem  [0:RQ_W];
    logic [RQ_W-1:0] w_rlq   [0:RQ_W];
    logic [HW-1:0]   w_rdiv  [0:RQ_W];
    logic            w_rside [0:RQ_W];

    assign w_rrem[0]  = w_n[NW-1:RQ_W];
    assign w_rlq[0]   = w_n[RQ_W-1:0];
    assign w_rdiv[0]  = r_s0_hi;
    assign w_rside[0] = r_s0_scaled;

    for (genvar g = 0; g < RQ_W; g++) begin : g_rcell
        ctre_div_cell #(.D_W(HW), .Q_W(RQ_W), .S_W(1)) u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rem  (w_rrem[g]),
            .i_lq   (w_rlq[g]),
            .i_div  (w_rdiv[g]),
            .i_side (w_rside[g]),
            .o_rem  (w_rrem[g+1]),
            .o_lq   (w_rlq[g+1]),
            .o_div  (w_rdiv[g+1]),
            .o_side (w_rside[g+1])
        );
    end

    // power chain
    t_rp  w_rp [0:3];
    logic w_ps [0:3];

    assign w_rp[0] = {{((NPOW-2)*RQ_W){1'b0}}, w_rlq[RQ_W], Q30_ONE};
    assign w_ps[0] = w_rside[RQ_W];

    for (genvar g = 0; g < 3; g++) begin : g_pcell
        ctre_pow_cell #(.IDX(g + 1)) u_cell (
            .i_clk    (i_clk),
            .i_en     (w_en),
            .i_rp     (w_rp[g]),
            .i_scaled (w_ps[g]),
            .o_rp     (w_rp[g+1]),
            .o_scaled (w_ps[g+1])
        );
    end

    // E1: coefficient products
    logic [2:0]       w_nn;
    logic [2:0]       w_idx [0:NPOW-1];
    logic [PR_W-1:0]  n_e1_prod [0:NPOW-1];
    logic [1:0]       n_e1_e [0:NPOW-1];
    logic [NUM_W-1:0] n_e1_num;
    logic [31:0]      w_rpn_rnd;
    logic [PR_W-1:0]  r_e1_prod [0:NPOW-1];
    logic [1:0]       r_e1_e [0:NPOW-1];
    logic [NUM_W-1:0] r_e1_num;
    logic             r_e1_flat;

    always_comb begin
        w_nn = (r_order > 3'd4) ? 3'd4 : r_order;
        for (int m = 0; m < NPOW; m++) begin
            w_idx[m] = (r_lowpass == w_ps[3]) ? w_nn - 3'(m) : 3'(m);
            n_e1_e[m] = r_lowpass ? w_idx[m][1:0] : 2'(3'd0 - (w_nn - w_idx[m]));
            n_e1_prod[m] = (3'(m) <= w_nn) ?
                PR_W'(coef(w_nn, r_kind, w_idx[m])) * PR_W'(w_rp[3][m]) : '0;
        end
        w_rpn_rnd = ({1'b0, w_rp[3][w_nn]} + 32'd128) >> 8;
        n_e1_num  = w_ps[3] ? w_rpn_rnd[NUM_W-1:0] : Q22_ONE;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e1_prod <= n_e1_prod;
            r_e1_e    <= n_e1_e;
            r_e1_num  <= n_e1_num;
            r_e1_flat <= (w_nn == 3'd0);
        end
    end

    // E2: accumulate into +re, +im, -re, -im
    logic [AC_W-1:0]  n_e2_acc [0:3];
    logic [AC_W-1:0]  r_e2_acc [0:3];
    logic [NUM_W-1:0] r_e2_num;
    logic             r_e2_flat;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_e2_acc[k] = '0;
            for (int m = 0; m < NPOW; m++) begin
                if (r_e1_e[m] == 2'(k)) n_e2_acc[k] = n_e2_acc[k] + AC_W'(r_e1_prod[m]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e2_acc  <= n_e2_acc;
            r_e2_num  <= r_e1_num;
            r_e2_flat <= r_e1_flat;
        end
    end

    // E3: signed parts of the denominator, Q22
    logic            w_an;
    logic            w_bn;
    logic [AC_W:0]   w_ad;
    logic [AC_W:0]   w_bd;
    logic [AC_W:0]   w_ar;
    logic [AC_W:0]   w_br;
    logic [AM_W-1:0] r_e3_a;
    logic [AM_W-1:0] r_e3_b;
    logic            r_e3_an;
    logic            r_e3_bn;
    logic [NUM_W-1:0] r_e3_num;

    always_comb begin
        w_an = r_e2_acc[2] > r_e2_acc[0];
        w_bn = r_e2_acc[3] > r_e2_acc[1];
        w_ad = w_an ? (AC_W+1)'(r_e2_acc[2] - r_e2_acc[0])
                    : (AC_W+1)'(r_e2_acc[0] - r_e2_acc[2]);
        w_bd = w_bn ? (AC_W+1)'(r_e2_acc[3] - r_e2_acc[1])
                    : (AC_W+1)'(r_e2_acc[1] - r_e2_acc[3]);
        w_ar = (w_ad + ((AC_W+1)'(1) << 31)) >> 32;
        w_br = (w_bd + ((AC_W+1)'(1) << 31)) >> 32;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_e2_flat) begin
                r_e3_a   <= AM_W'(Q22_ONE);
                r_e3_b   <= '0;
                r_e3_an  <= 1'b0;
                r_e3_bn  <= 1'b0;
                r_e3_num <= Q22_ONE;
            end else begin
                r_e3_a   <= w_ar[AM_W-1:0];
                r_e3_b   <= w_br[AM_W-1:0];
                r_e3_an  <= w_an;
                r_e3_bn  <= w_bn;
                r_e3_num <= r_e2_num;
            end
        end
    end

    // E4: squares and numerator products
    logic [SQ_W-1:0] r_e4_aa;
    logic [SQ_W-1:0] r_e4_bb;
    logic [NA_W-1:0] r_e4_na;
    logic [NA_W-1:0] r_e4_nb;
    logic            r_e4_an;
    logic            r_e4_bn;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e4_aa <= SQ_W'(r_e3_a) * SQ_W'(r_e3_a);
            r_e4_bb <= SQ_W'(r_e3_b) * SQ_W'(r_e3_b);
            r_e4_na <= NA_W'(r_e3_num) * NA_W'(r_e3_a);
            r_e4_nb <= NA_W'(r_e3_num) * NA_W'(r_e3_b);
            r_e4_an <= r_e3_an;
            r_e4_bn <= r_e3_bn;
        end
    end

    // E5: |D|^2 and gain partial products
    logic [DEN_W-1:0] w_den;
    logic [GS_W-1:0]  w_gs;
    logic [DEN_W-1:0] r_e5_den;
    logic [P_W-1:0]   r_e5_pla;
    logic [P_W-1:0]   r_e5_pha;
    logic [P_W-1:0]   r_e5_plb;
    logic [P_W-1:0]   r_e5_phb;
    logic             r_e5_an;
    logic             r_e5_bn;

    always_comb begin
        w_den = (DEN_W'(r_e4_aa) + DEN_W'(r_e4_bb)) << DN;
        if (w_den == '0) w_den = DEN_W'(1);
        w_gs = GS_W'(r_gain) << UP;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e5_den <= w_den;
            r_e5_pla <= P_W'(w_gs) * P_W'(r_e4_na[LO_W-1:0]);
            r_e5_pha <= P_W'(w_gs) * P_W'(r_e4_na[NA_W-1:LO_W]);
            r_e5_plb <= P_W'(w_gs) * P_W'(r_e4_nb[LO_W-1:0]);
            r_e5_phb <= P_W'(w_gs) * P_W'(r_e4_nb[NA_W-1:LO_W]);
            r_e5_an  <= r_e4_an;
            r_e5_bn  <= r_e4_bn;
        end
    end

    // E6: full dividends
    logic [DV_W-1:0]  r_e6_dva;
    logic [DV_W-1:0]  r_e6_dvb;
    logic [DEN_W-1:0] r_e6_den;
    logic             r_e6_an;
    logic             r_e6_bn;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e6_dva <= DV_W'(r_e5_pla) + (DV_W'(r_e5_pha) << LO_W);
            r_e6_dvb <= DV_W'(r_e5_plb) + (DV_W'(r_e5_phb) << LO_W);
            r_e6_den <= r_e5_den;
            r_e6_an  <= r_e5_an;
            r_e6_bn  <= r_e5_bn;
        end
    end

    // output divider chains
    logic [DEN_W-1:0] w_arem  [0:QB];
    logic [QB-1:0]    w_alq   [0:QB];
    logic [DEN_W-1:0] w_aden  [0:QB];
    logic             w_aside [0:QB];
    logic [DEN_W-1:0] w_brem  [0:QB];
    logic [QB-1:0]    w_blq   [0:QB];
    logic [DEN_W-1:0] w_bden  [0:QB];
    logic             w_bside [0:QB];

    assign w_arem[0]  = DEN_W'(r_e6_dva[DV_W-1:QB]);
    assign w_alq[0]   = r_e6_dva[QB-1:0];
    assign w_aden[0]  = r_e6_den;
    assign w_aside[0] = r_e6_an;
    assign w_brem[0]  = DEN_W'(r_e6_dvb[DV_W-1:QB]);
    assign w_blq[0]   = r_e6_dvb[QB-1:0];
    assign w_bden[0]  = r_e6_den;
    assign w_bside[0] = r_e6_bn;

    for (genvar g = 0; g < QB; g++) begin : g_ocell
        ctre_div_cell #(.D_W(DEN_W), .Q_W(QB), .S_W(1)) u_re (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rem  (w_arem[g]),
            .i_lq   (w_alq[g]),
            .i_div  (w_aden[g]),
            .i_side (w_aside[g]),
            .o_rem  (w_arem[g+1]),
            .o_lq   (w_alq[g+1]),
            .o_div  (w_aden[g+1]),
            .o_side (w_aside[g+1])
        );
        ctre_div_cell #(.D_W(DEN_W), .Q_W(QB), .S_W(1)) u_im (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rem  (w_brem[g]),
            .i_lq   (w_blq[g]),
            .i_div  (w_bden[g]),
            .i_side (w_bside[g]),
            .o_rem  (w_brem[g+1]),
            .o_lq   (w_blq[g+1]),
            .o_div  (w_bden[g+1]),
            .o_side (w_bside[g+1])
        );
    end

    // rounding and saturation
    function automatic logic [OUT_W:0] pack_part(input logic [QB:0] mag, input logic neg);
        logic [QB:0]      m;
        logic             s;
        logic [OUT_W-1:0] v;
        m = mag;
        s = 1'b0;
        if (!neg) begin
            if (m > (QB+1)'(OUT_POS_MAX)) begin
                s = 1'b1;
                v = OUT_W'(OUT_POS_MAX);
            end else begin
                v = m[OUT_W-1:0];
            end
        end else begin
            if (m > (QB+1)'(OUT_NEG_MAG)) begin
                s = 1'b1;
                m = (QB+1)'(OUT_NEG_MAG);
            end
            v = OUT_W'(0) - m[OUT_W-1:0];
        end
        return {s, v};
    endfunction

    logic [QB:0]      w_amag;
    logic [QB:0]      w_bmag;
    logic [OUT_W:0]   w_apk;
    logic [OUT_W:0]   w_bpk;
    logic [OUT_W-1:0] w_re;
    logic [OUT_W-1:0] w_im;
    logic             w_sat;

    always_comb begin
        w_amag = {1'b0, w_alq[QB]}
               + (QB+1)'({w_arem[QB], 1'b0} >= {1'b0, w_aden[QB]});
        w_bmag = {1'b0, w_blq[QB]}
               + (QB+1)'({w_brem[QB], 1'b0} >= {1'b0, w_bden[QB]});
        w_apk  = pack_part(w_amag, w_aside[QB] && (w_amag != '0));
        w_bpk  = pack_part(w_bmag, !w_bside[QB] && (w_bmag != '0));
        w_re   = w_apk[OUT_W-1:0];
        w_im   = w_bpk[OUT_W-1:0];
        w_sat  = w_apk[OUT_W] | w_bpk[OUT_W];
    end

    // output register and skid
    logic [OUT_W-1:0] r_out_re;
    logic [OUT_W-1:0] r_out_im;
    logic             r_out_sat;
    logic [OUT_W-1:0] r_skid_re;
    logic [OUT_W-1:0] r_skid_im;
    logic             r_skid_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= w_last_v;
            end
        end else if (w_en && w_last_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_v) begin
                r_out_re  <= r_skid_re;
                r_out_im  <= r_skid_im;
                r_out_sat <= r_skid_sat;
            end else begin
                r_out_re  <= w_re;
                r_out_im  <= w_im;
                r_out_sat <= w_sat;
            end
        end else if (w_en) begin
            r_skid_re  <= w_re;
            r_skid_im  <= w_im;
            r_skid_sat <= w_sat;
        end
    end

    assign o_out_valid     = r_out_v;
    assign o_response_real = r_out_re;
    assign o_response_imag = r_out_im;
    assign o_saturated     = r_out_sat;

    // skid only fills behind a waiting result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid holds a result while output register is empty");

    // pipeline frozen while the skid is full
    a_pipe_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |=> $stable(r_vld))
        else $error("pipeline moved while skid was full");

    // ratio divider leaves a remainder below the divisor
    a_ratio_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[RQ_W] |-> (w_rrem[RQ_W] < w_rdiv[RQ_W]) && (w_rlq[RQ_W] <= Q30_ONE))
        else $error("ratio divider out of range");

    // a clipped result sits on a limit
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out_sat) |->
            (r_out_re == OUT_W'(OUT_POS_MAX)) || (r_out_re == OUT_W'(OUT_NEG_MAG)) ||
            (r_out_im == OUT_W'(OUT_POS_MAX)) || (r_out_im == OUT_W'(OUT_NEG_MAG)))
        else $error("saturation flag without a clipped part");

endmodule

>>> hw/rtl/ctre_div_cell.sv
// ctre_div_cell: one restoring division step, one quotient bit per cell,
// registered; divisor and sideband ride along. No dependencies.
module ctre_div_cell #(
    parameter int D_W = 20,
    parameter int Q_W = 31,
    parameter int S_W = 1
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [D_W-1:0] i_rem,
    input  logic [Q_W-1:0] i_lq,
    input  logic [D_W-1:0] i_div,
    input  logic [S_W-1:0] i_side,
    output logic [D_W-1:0] o_rem,
    output logic [Q_W-1:0] o_lq,
    output logic [D_W-1:0] o_div,
    output logic [S_W-1:0] o_side
);

    logic [D_W:0]   w_try;
    logic [D_W:0]   w_sub;
    logic           w_ge;
    logic [D_W-1:0] n_rem;
    logic [Q_W-1:0] n_lq;
    logic [D_W-1:0] r_rem;
    logic [Q_W-1:0] r_lq;
    logic [D_W-1:0] r_div;
    logic [S_W-1:0] r_side;

    always_comb begin
        w_try = {i_rem, i_lq[Q_W-1]};
        w_ge  = w_try >= {1'b0, i_div};
        w_sub = w_try - {1'b0, i_div};
        n_rem = w_ge ? w_sub[D_W-1:0] : w_try[D_W-1:0];
        n_lq  = {i_lq[Q_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_lq   <= n_lq;
            r_div  <= i_div;
            r_side <= i_side;
        end
    end

    assign o_rem  = r_rem;
    assign o_lq   = r_lq;
    assign o_div  = r_div;
    assign o_side = r_side;

endmodule

>>> hw/rtl/ctre_pow_cell.sv
// ctre_pow_cell: registered step of the ratio power chain, rp[IDX+1] = rp[IDX] * r
// in Q30 rounded half up. Depends on ctre_pkg.
module ctre_pow_cell #(
    parameter int IDX = 1
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  ctre_pkg::t_rp  i_rp,
    input  logic           i_scaled,
    output ctre_pkg::t_rp  o_rp,
    output logic           o_scaled
);
    import ctre_pkg::*;

    logic [2*RQ_W-1:0] w_prod;
    t_rp               n_rp;
    t_rp               r_rp;
    logic              r_scaled;

    always_comb begin
        w_prod = (2*RQ_W)'(i_rp[IDX]) * (2*RQ_W)'(i_rp[1]);
        n_rp = i_rp;
        n_rp[IDX+1] = RQ_W'((w_prod + ((2*RQ_W)'(1) << (RQ_W-2))) >> (RQ_W-1));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rp     <= n_rp;
            r_scaled <= i_scaled;
        end
    end

    assign o_rp     = r_rp;
    assign o_scaled = r_scaled;

endmodule

>>> tb/tb_crossover_target_response_eval_core.sv
// tb_crossover_target_response_eval_core: self-checking testbench for the
// crossover target response evaluator, with an internal fixed-point predictor.
// Depends on ctre_pkg and crossover_target_response_eval_core.
`timescale 1ns / 100ps

module tb_crossover_target_response_eval_core;
    import ctre_pkg::*;

    localparam int RUN_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 100;

    typedef struct packed {
        logic [OUT_W-1:0] re;
        logic [OUT_W-1:0] im;
        logic             sat;
    } t_resp;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 o_in_ready;
    logic [19:0]          frequency = '0;
    logic                 o_out_valid;
    logic                 out_ready = 1'b0;
    logic signed [OUT_W-1:0] o_response_real;
    logic signed [OUT_W-1:0] o_response_imag;
    logic                 o_saturated;
    logic                 cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    t_cfg_idx             cfg_index = CFG_ORDER;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    crossover_target_response_eval_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_frequency    (frequency),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_response_real(o_response_real),
        .o_response_imag(o_response_imag),
        .o_saturated    (o_saturated),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor copy of the registers
    logic [2:0]  m_order = 3'd2;
    logic [2:0]  m_kind = 3'd1;
    logic        m_lowpass = 1'b1;
    logic [19:0] m_corner = 20'd16000;
    logic [19:0] m_gain = 20'd65536;

    t_resp expected_resp[$];
    int    fail_count = 0;
    int    cycle_count = 0;

    // sender pacing
    bit sender_gaps = 1'b1;
    int burst_left = 0;

    // receiver pacing
    int stall_mode = 1;
    int pat_cnt = 0;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_cnt = 0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("crossover_target_response_eval_core test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        pat_cnt <= pat_cnt + 1;
        if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            hold_cnt <= 400;
            out_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            out_ready <= 1'b0;
        end else if (stall_mode == 0) begin
            out_ready <= 1'b1;
        end else if (stall_mode == 1) begin
            out_ready <= ($urandom_range(0, 9) < 7);
        end else begin
            out_ready <= ((pat_cnt % 7) < 3);
        end
    end

    always @(posedge i_clk) begin
        t_resp exp_r;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (expected_resp.size() == 0) begin
                $error("unexpected result transfer");
                fail_count++;
            end else begin
                exp_r = expected_resp.pop_front();
                if (o_response_real !== exp_r.re) begin
                    $error("response_real expected %0d actual %0d",
                           $signed(exp_r.re), o_response_real);
                    fail_count++;
                end
                if (o_response_imag !== exp_r.im) begin
                    $error("response_imag expected %0d actual %0d",
                           $signed(exp_r.im), o_response_imag);
                    fail_count++;
                end
                if (o_saturated !== exp_r.sat) begin
                    $error("saturated expected %0d actual %0d", exp_r.sat, o_saturated);
                    fail_count++;
                end
            end
        end
    end

    function automatic bit [63:0] div_round(bit [63:0] x, bit [63:0] y, bit [63:0] d,
                                            output bit over);
        bit [127:0] prod, q, rem;
        prod = {64'd0, x} * {64'd0, y};
        q = prod / d;
        rem = prod - q * d;
        if (rem >= d - rem) q = q + 1;
        over = (q >= (128'd1 << 40));
        return q[63:0];
    endfunction

    function automatic logic [OUT_W-1:0] clip_part(bit [63:0] mag, bit neg, bit over,
                                                   inout bit sat);
        if (!neg) begin
            if (over || mag > OUT_POS_MAX) begin
                sat = 1'b1;
                return OUT_W'(OUT_POS_MAX);
            end
            return mag[OUT_W-1:0];
        end
        if (over || mag > OUT_NEG_MAG) begin
            sat = 1'b1;
            mag = 64'(OUT_NEG_MAG);
        end
        return (~mag[OUT_W-1:0]) + 1'b1;
    endfunction

    function automatic t_resp calc_response(logic [19:0] f);
        bit [63:0] fc, lo, hi, ratio, a_mag, b_mag, num, den, mag;
        bit [63:0] pw[5];
        bit [63:0] cf[5];
        bit [63:0] acc[4];
        int        n, m, idx, e;
        bit        lp, scaled, a_neg, b_neg, over, sat;
        t_resp     r;
        fc = (m_corner == 0) ? 64'd1 : 64'(m_corner);
        n = (m_order > 4) ? 4 : int'(m_order);
        a_mag = 64'd4194304;
        b_mag = 0;
        num = 64'd4194304;
        a_neg = 0;
        b_neg = 0;
        sat = 0;
        if (n != 0) begin
            lp = m_lowpass;
            scaled = lp ? (64'(f) > fc) : (64'(f) < fc);
            lo = (64'(f) < fc) ? 64'(f) : fc;
            hi = (64'(f) < fc) ? fc : 64'(f);
            ratio = ((lo << 30) + hi / 2) / hi;
            for (m = 0; m < 5; m++) cf[m] = 0;
            cf[0] = 64'd16777216;
            cf[n] = 64'd16777216;
            if (n == 2) begin
                case (m_kind)
                    3'd0: cf[1] = 64'd29058991;
                    3'd1: cf[1] = 64'd23726566;
                    3'd2: cf[1] = 64'd16777216;
                    default: cf[1] = 64'd33554432;
                endcase
            end else if (n == 3) begin
                cf[1] = 64'd33554432;
                cf[2] = 64'd33554432;
            end else if (n == 4) begin
                if (m_kind == 3'd0) begin
                    cf[1] = 64'd53703868;
                    cf[2] = 64'd73685533;
                    cf[3] = 64'd52412023;
                end else if (m_kind == 3'd1) begin
                    cf[1] = 64'd43838865;
                    cf[2] = 64'd57277415;
                    cf[3] = 64'd43838865;
                end else begin
                    cf[1] = 64'd47453133;
                    cf[2] = 64'd67108864;
                    cf[3] = 64'd47453133;
                end
            end
            pw[0] = 64'd1073741824;
            for (m = 1; m <= n; m++) pw[m] = (pw[m-1] * ratio + 64'd536870912) >> 30;
            for (m = 0; m < 4; m++) acc[m] = 0;
            for (m = 0; m <= n; m++) begin
                idx = (lp == scaled) ? n - m : m;
                e = lp ? idx : 3 * (n - idx);
                acc[e & 3] += cf[idx] * pw[m];
            end
            a_neg = acc[2] > acc[0];
            a_mag = a_neg ? acc[2] - acc[0] : acc[0] - acc[2];
            a_mag = (a_mag + (64'd1 << 31)) >> 32;
            b_neg = acc[3] > acc[1];
            b_mag = b_neg ? acc[3] - acc[1] : acc[1] - acc[3];
            b_mag = (b_mag + (64'd1 << 31)) >> 32;
            if (scaled) num = (pw[n] + 64'd128) >> 8;
        end
        den = a_mag * a_mag + b_mag * b_mag;
        if (den == 0) den = 1;
        mag = div_round(64'(m_gain), num * a_mag, den, over);
        r.re = clip_part(mag, a_neg && mag != 0, over, sat);
        mag = div_round(64'(m_gain), num * b_mag, den, over);
        r.im = clip_part(mag, !b_neg && mag != 0, over, sat);
        r.sat = sat;
        return r;
    endfunction

    task automatic write_reg(t_cfg_idx idx, int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DAT_W'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ORDER:   m_order = 3'(value);
            CFG_KIND:    m_kind = 3'(value);
            CFG_LOWPASS: m_lowpass = value[0];
            CFG_CORNER:  m_corner = 20'(value);
            CFG_GAIN:    m_gain = 20'(value);
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_filter(int order, int kind, int lowpass, int corner, int gain);
        write_reg(CFG_ORDER, order);
        write_reg(CFG_KIND, kind);
        write_reg(CFG_LOWPASS, lowpass);
        write_reg(CFG_CORNER, corner);
        write_reg(CFG_GAIN, gain);
    endtask

    task automatic send_freq(logic [19:0] f);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = sender_gaps ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        frequency <= f;
        do @(posedge i_clk); while (!o_in_ready);
        expected_resp.push_back(calc_response(f));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_resp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [19:0] pick_freq();
        int unsigned fc;
        fc = (m_corner == 0) ? 1 : m_corner;
        case ($urandom_range(0, 4))
            0: return 20'($urandom_range(0, 20'hFFFFF));
            1: return 20'($urandom_range(fc / 2,
                                          (fc * 2 > 20'hFFFFF) ? 20'hFFFFF : fc * 2));
            2: return 20'($urandom_range(0, (fc > 20'hFFFFF / 8) ? 20'hFFFFF : fc * 8));
            3: return 20'($urandom_range(0, 64));
            default: return ($urandom_range(0, 1) != 0) ? 20'hFFFFF : fc[19:0];
        endcase
    endfunction

    task automatic test_reset_values();
        send_freq(20'd0);
        send_freq(20'd16000);
        send_freq(20'd64000);
        drain_results();
    endtask

    task automatic test_special_cases();
        // flat response, high-pass mode, maximum gain
        set_filter(0, 3, 0, 100, 20'hFFFFF);
        send_freq(20'd0);
        send_freq(20'hFFFFF);
        drain_results();
        // high-pass at zero, order three with an unrelated kind, corner zero
        set_filter(3, 6, 0, 0, 65536);
        send_freq(20'd0);
        send_freq(20'd1);
        send_freq(20'hFFFFF);
        drain_results();
        // order above four and an unset order-four kind, gain zero then large
        set_filter(7, 2, 1, 1, 0);
        send_freq(20'd1);
        send_freq(20'd2);
        drain_results();
        set_filter(4, 7, 1, 20'hFFFFF, 20'hFFFFF);
        send_freq(20'hFFFFF);
        send_freq(20'd524288);
        drain_results();
        // order one, order two bessel and chebyshev at the corner, order four bessel off it
        set_filter(1, 5, 0, 4000, 131072);
        send_freq(20'd4000);
        send_freq(20'd2);
        drain_results();
        set_filter(2, 0, 1, 4000, 65536);
        send_freq(20'd4000);
        drain_results();
        set_filter(2, 2, 0, 4000, 65536);
        send_freq(20'd4000);
        send_freq(20'd100);
        drain_results();
        set_filter(4, 0, 0, 16000, 300000);
        send_freq(20'd3000);
        send_freq(20'd90000);
        drain_results();
    endtask

    task automatic test_random_settings();
        int order, corner;
        for (int ph = 0; ph < 10; ph++) begin
            order = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
            case ($urandom_range(0, 5))
                0: corner = $urandom_range(0, 100);
                1: corner = 20'hFFFFF;
                default: corner = $urandom_range(1, 20'hFFFFF);
            endcase
            set_filter(order, $urandom_range(0, 7), $urandom_range(0, 1), corner,
                       $urandom_range(0, 20'hFFFFF));
            sender_gaps = (ph % 3) != 2;
            stall_mode = ph % 3;
            for (int k = 0; k < 45; k++) send_freq(pick_freq());
            drain_results();
        end
    endtask

    task automatic test_output_backpressure();
        set_filter(4, 1, 1, 2000, 65536);
        sender_gaps = 1'b0;
        hold_req++;
        for (int k = 0; k < 150; k++) send_freq(pick_freq());
        sender_gaps = 1'b1;
        drain_results();
    endtask

    task automatic test_sender_pause();
        set_filter(2, 3, 0, 8000, 200000);
        stall_mode = 1;
        for (int k = 0; k < 20; k++) send_freq(pick_freq());
        in_valid <= 1'b0;
        while (expected_resp.size() != 0) @(posedge i_clk);
        for (int k = 0; k < 20; k++) send_freq(pick_freq());
        drain_results();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_special_cases();
        test_random_settings();
        test_output_backpressure();
        test_sender_pause();
        if (fail_count == 0) begin
            $display("crossover_target_response_eval_core test passed");
        end else begin
            $display("crossover_target_response_eval_core test failed");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/ctre_pkg.sv
hw/rtl/ctre_div_cell.sv
hw/rtl/ctre_pow_cell.sv
hw/rtl/crossover_target_response_eval_core.sv
tb/tb_crossover_target_response_eval_core.sv
